/* hdl/kppt_pkg.sv */
// Package for the keypad poll presence tracker.
// Holds the beat payload types, register indexes and bus action codes.
// No dependencies.
package kppt_pkg;

  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned IntvWidth  = 16;
  localparam int unsigned LimitWidth = 8;
  localparam int unsigned RawWidth   = 8;
  localparam int unsigned KeyWidth   = 7;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [LimitWidth-1:0] CountMax = 8'd255;

  localparam logic [IntvWidth-1:0]  PollIntervalRst    = 16'd10;
  localparam logic [IntvWidth-1:0]  ReprobeIntervalRst = 16'd4000;
  localparam logic [LimitWidth-1:0] FailureLimitRst    = 8'd3;

  typedef enum logic [0:0] {
    FUNC_BOOT = 1'b0,
    FUNC_POLL = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    BUS_NONE       = 2'd0,
    BUS_PROBE      = 2'd1,
    BUS_PROBE_READ = 2'd2
  } bus_action_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_POLL_INTERVAL    = 2'd0,
    REG_REPROBE_INTERVAL = 2'd1,
    REG_FAILURE_LIMIT    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                 func;
    logic [TimeWidth-1:0] now_ms;
    logic                 probe_ack;
    logic                 byte_valid;
    logic [RawWidth-1:0]  key_byte;
  } in_item_t;

  typedef struct packed {
    logic [KeyWidth-1:0] key_event;
    logic [1:0]          bus_action;
    logic                device_present;
    logic                device_lost;
    logic [RawWidth-1:0] last_nonzero_key;
  } out_item_t;

endpackage

/* hdl/kppt_channels.sv */
// Valid/ready channel interfaces for the keypad poll presence tracker.
// Depends on kppt_pkg for the payload types.
interface kppt_in_if import kppt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kppt_out_if import kppt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kppt_cfg_if import kppt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/keypad_poll_presence_tracker_unit.sv */
// Keypad poll presence tracker, top level.
// An accepted input beat is held in the input register; its result is offered from the
// result register. Throughput: one beat per cycle unless the result channel stalls;
// the two registers decouple the channels, so a stalled result costs at most one held beat.
// Reset: synchronous active-low rst_n clears all tracking state and loads the
// register defaults (poll 10 ms, re-probe 4000 ms, failure limit 3).
module keypad_poll_presence_tracker_unit import kppt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  kppt_in_if.sink    in_ch,
  kppt_out_if.source out_ch,
  kppt_cfg_if.sink   cfg_ch
);

  logic [IntvWidth-1:0]  poll_intv_r;
  logic [IntvWidth-1:0]  reprobe_intv_r;
  logic [LimitWidth-1:0] fail_limit_r;

  logic                  present_r, present_nxt;
  logic                  lost_r, lost_nxt;
  logic [LimitWidth-1:0] fail_cnt_r, fail_cnt_nxt;
  logic [TimeWidth-1:0]  last_poll_r, last_poll_nxt;
  logic [TimeWidth-1:0]  last_reprobe_r, last_reprobe_nxt;
  logic [KeyWidth-1:0]   prev_key_r, prev_key_nxt;
  logic [RawWidth-1:0]   seen_key_r, seen_key_nxt;

  logic      s1_v_r, s1_v_nxt;
  in_item_t  s1_item_r;
  logic      out_v_r, out_v_nxt;
  out_item_t out_item_r, res;

  logic                  out_free, in_fire, work;
  logic [TimeWidth-1:0]  poll_age, reprobe_age;
  logic [LimitWidth-1:0] cnt_inc;
  logic [RawWidth-1:0]   key_raw;
  logic [KeyWidth-1:0]   key_filt;
  bus_action_t           action;
  logic [KeyWidth-1:0]   event_key;

  assign out_free     = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign work         = s1_v_r && out_free;
  assign s1_v_nxt     = in_fire || (s1_v_r && !out_free);
  assign out_v_nxt    = work || (out_v_r && !out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_item_r;

  assign poll_age    = s1_item_r.now_ms - last_poll_r;
  assign reprobe_age = s1_item_r.now_ms - last_reprobe_r;
  assign cnt_inc     = (fail_cnt_r == CountMax) ? fail_cnt_r : fail_cnt_r + 1'b1;
  assign key_raw     = s1_item_r.byte_valid ? s1_item_r.key_byte : '0;
  assign key_filt    = key_raw[RawWidth-1] ? '0 : key_raw[KeyWidth-1:0];

  always_comb begin
    present_nxt      = present_r;
    lost_nxt         = lost_r;
    fail_cnt_nxt     = fail_cnt_r;
    last_poll_nxt    = last_poll_r;
    last_reprobe_nxt = last_reprobe_r;
    prev_key_nxt     = prev_key_r;
    seen_key_nxt     = seen_key_r;
    action           = BUS_NONE;
    event_key        = '0;
    if (s1_item_r.func == FUNC_BOOT) begin
      action = BUS_PROBE;
      if (s1_item_r.probe_ack) begin
        present_nxt = 1'b1;
      end
    end else if (!present_r) begin
      if (lost_r && (reprobe_age >= {{(TimeWidth-IntvWidth){1'b0}}, reprobe_intv_r})) begin
        last_reprobe_nxt = s1_item_r.now_ms;
        action           = BUS_PROBE;
        if (s1_item_r.probe_ack) begin
          present_nxt  = 1'b1;
          lost_nxt     = 1'b0;
          fail_cnt_nxt = '0;
        end
      end
    end else if (poll_age >= {{(TimeWidth-IntvWidth){1'b0}}, poll_intv_r}) begin
      last_poll_nxt = s1_item_r.now_ms;
      if (!s1_item_r.probe_ack) begin
        action       = BUS_PROBE;
        fail_cnt_nxt = cnt_inc;
        if (cnt_inc >= fail_limit_r) begin
          present_nxt      = 1'b0;
          lost_nxt         = 1'b1;
          last_reprobe_nxt = s1_item_r.now_ms;
        end
      end else begin
        action = BUS_PROBE_READ;
        if (s1_item_r.byte_valid) begin
          fail_cnt_nxt = '0;
        end
        if (key_raw != '0) begin
          seen_key_nxt = key_raw;
        end
        if ((key_filt != '0) && (prev_key_r == '0)) begin
          event_key = key_filt;
        end
        prev_key_nxt = key_filt;
      end
    end
  end

  always_comb begin
    res.key_event        = event_key;
    res.bus_action       = action;
    res.device_present   = present_nxt;
    res.device_lost      = lost_nxt;
    res.last_nonzero_key = seen_key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_intv_r    <= PollIntervalRst;
      reprobe_intv_r <= ReprobeIntervalRst;
      fail_limit_r   <= FailureLimitRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_POLL_INTERVAL:    poll_intv_r    <= cfg_ch.data;
        REG_REPROBE_INTERVAL: reprobe_intv_r <= cfg_ch.data;
        REG_FAILURE_LIMIT:    fail_limit_r   <= cfg_ch.data[LimitWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r      <= 1'b0;
      lost_r         <= 1'b0;
      fail_cnt_r     <= '0;
      last_poll_r    <= '0;
      last_reprobe_r <= '0;
      prev_key_r     <= '0;
      seen_key_r     <= '0;
    end else if (work) begin
      present_r      <= present_nxt;
      lost_r         <= lost_nxt;
      fail_cnt_r     <= fail_cnt_nxt;
      last_poll_r    <= last_poll_nxt;
      last_reprobe_r <= last_reprobe_nxt;
      prev_key_r     <= prev_key_nxt;
      seen_key_r     <= seen_key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_ch.data;
    end
    if (work) begin
      out_item_r <= res;
    end
  end

  a_event_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_item_r.key_event != '0) |->
      (out_item_r.bus_action == BUS_PROBE_READ) && out_item_r.device_present)
    else $error("key event reported without a successful read");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_item_r.bus_action == BUS_NONE) ||
      (out_item_r.bus_action == BUS_PROBE) || (out_item_r.bus_action == BUS_PROBE_READ))
    else $error("undefined bus action in result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && out_v_r && !out_ch.ready)
    else $error("input stalled while a stage was free");

  a_state_frozen_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !work |=> $stable(fail_cnt_r) && $stable(seen_key_r) && $stable(prev_key_r))
    else $error("tracking state changed without a beat");

endmodule

/* dv/keypad_poll_presence_tracker_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for keypad_poll_presence_tracker_unit: drives boot and poll beats with random idling,
// predicts every result beat in-line and compares it field by field with the block's output.
// Depends on kppt_pkg, the kppt channel interfaces and the RTL of the block.
module keypad_poll_presence_tracker_unit_tb;
  import kppt_pkg::*;

  localparam int unsigned StallLimit = 400;

  logic clk = 1'b0;
  logic rst_n;

  kppt_in_if  in_ch ();
  kppt_out_if out_ch ();
  kppt_cfg_if cfg_ch ();

  keypad_poll_presence_tracker_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [IntvWidth-1:0]  cur_poll_intv;
  logic [IntvWidth-1:0]  cur_reprobe_intv;
  logic [LimitWidth-1:0] cur_fail_limit;

  logic                  trk_present;
  logic                  trk_lost;
  logic [LimitWidth-1:0] trk_fails;
  logic [TimeWidth-1:0]  trk_poll_ms;
  logic [TimeWidth-1:0]  trk_reprobe_ms;
  logic [KeyWidth-1:0]   trk_prev_key;
  logic [RawWidth-1:0]   trk_seen_byte;

  out_item_t key_report_q[$];

  int mismatches;
  int items_sent;
  int results_checked;
  int idle_cycles = 0;
  int src_quiet;
  int sink_quiet = 0;
  int sink_wait = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t track_poll(input in_item_t it);
    out_item_t            r;
    logic [RawWidth-1:0]  key;
    logic [TimeWidth-1:0] elapsed;
    r = '0;
    key = '0;
    r.bus_action = BUS_NONE;
    if (it.func == FUNC_BOOT) begin
      r.bus_action = BUS_PROBE;
      if (it.probe_ack) trk_present = 1'b1;
    end else if (!trk_present) begin
      elapsed = it.now_ms - trk_reprobe_ms;
      if (trk_lost && elapsed >= {16'd0, cur_reprobe_intv}) begin
        trk_reprobe_ms = it.now_ms;
        r.bus_action = BUS_PROBE;
        if (it.probe_ack) begin
          trk_present = 1'b1;
          trk_lost = 1'b0;
          trk_fails = '0;
        end
      end
    end else begin
      elapsed = it.now_ms - trk_poll_ms;
      if (elapsed >= {16'd0, cur_poll_intv}) begin
        trk_poll_ms = it.now_ms;
        if (!it.probe_ack) begin
          r.bus_action = BUS_PROBE;
          if (trk_fails != CountMax) trk_fails = trk_fails + 1'b1;
          if (trk_fails >= cur_fail_limit) begin
            trk_present = 1'b0;
            trk_lost = 1'b1;
            trk_reprobe_ms = it.now_ms;
          end
        end else begin
          r.bus_action = BUS_PROBE_READ;
          if (it.byte_valid) begin
            key = it.key_byte;
            trk_fails = '0;
          end
          if (key != '0) trk_seen_byte = key;
          if (key > 8'd127) key = '0;
          if (key != '0 && trk_prev_key == '0) r.key_event = key[KeyWidth-1:0];
          trk_prev_key = key[KeyWidth-1:0];
        end
      end
    end
    r.device_present = trk_present;
    r.device_lost = trk_lost;
    r.last_nonzero_key = trk_seen_byte;
    return r;
  endfunction

  function automatic in_item_t mk_item(input logic f, input logic [TimeWidth-1:0] t,
                                       input logic a, input logic v,
                                       input logic [RawWidth-1:0] k);
    in_item_t it;
    it.func = f;
    it.now_ms = t;
    it.probe_ack = a;
    it.byte_valid = v;
    it.key_byte = k;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (src_quiet > 0) begin
      src_quiet--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      src_quiet = $urandom_range(8, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    key_report_q.push_back(track_poll(it));
    items_sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    while (key_report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataWidth-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_POLL_INTERVAL:    cur_poll_intv = val;
      REG_REPROBE_INTERVAL: cur_reprobe_intv = val;
      REG_FAILURE_LIMIT:    cur_fail_limit = val[LimitWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [IntvWidth-1:0] poll, input logic [IntvWidth-1:0] reprobe,
                            input logic [LimitWidth-1:0] limit);
    settle();
    write_reg(REG_POLL_INTERVAL, poll);
    write_reg(REG_REPROBE_INTERVAL, reprobe);
    write_reg(REG_FAILURE_LIMIT, {8'd0, limit});
    cfg_ch.valid <= 1'b0;
  endtask

  // Polls on a running clock, with segments of mostly good, mixed or mostly failing probes
  // and a few boot beats and out-of-sequence timestamps mixed in.
  task automatic run_traffic(input int count, input int unsigned step_max,
                             input logic [TimeWidth-1:0] start_ms);
    logic [TimeWidth-1:0] clock_ms;
    logic [RawWidth-1:0]  key;
    int                   ack_pct;
    int                   seg_left;
    in_item_t             it;
    clock_ms = start_ms;
    seg_left = 0;
    ack_pct = 90;
    send_item(mk_item(FUNC_BOOT, clock_ms, 1'b1, 1'b0, 8'd0));
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 25);
        case ($urandom_range(0, 2))
          0: ack_pct = 15;
          1: ack_pct = 60;
          default: ack_pct = 95;
        endcase
      end
      seg_left--;
      clock_ms = clock_ms + $urandom_range(0, step_max);
      case ($urandom_range(0, 4))
        0: key = 8'd0;
        1, 2: key = 8'($urandom_range(1, 127));
        3: key = 8'($urandom_range(128, 255));
        default: key = 8'($urandom_range(0, 255));
      endcase
      it = mk_item(($urandom_range(0, 19) == 0) ? FUNC_BOOT : FUNC_POLL,
                   ($urandom_range(0, 29) == 0) ? $urandom() : clock_ms,
                   $urandom_range(0, 99) < ack_pct, $urandom_range(0, 4) != 0, key);
      send_item(it);
    end
    end_burst();
  endtask

  task automatic test_defaults_directed();
    send_item(mk_item(FUNC_POLL, 32'd100, 1'b1, 1'b1, 8'd5));
    send_item(mk_item(FUNC_BOOT, 32'd0, 1'b0, 1'b0, 8'd0));
    send_item(mk_item(FUNC_BOOT, 32'd0, 1'b1, 1'b0, 8'd0));
    send_item(mk_item(FUNC_POLL, 32'd5, 1'b1, 1'b1, 8'h11));
    send_item(mk_item(FUNC_POLL, 32'd10, 1'b1, 1'b1, 8'h41));
    send_item(mk_item(FUNC_POLL, 32'd20, 1'b1, 1'b1, 8'h42));
    send_item(mk_item(FUNC_POLL, 32'd30, 1'b1, 1'b0, 8'h33));
    send_item(mk_item(FUNC_POLL, 32'd40, 1'b1, 1'b1, 8'hFF));
    send_item(mk_item(FUNC_POLL, 32'd50, 1'b1, 1'b1, 8'h80));
    send_item(mk_item(FUNC_POLL, 32'd60, 1'b1, 1'b1, 8'h7F));
    send_item(mk_item(FUNC_POLL, 32'd70, 1'b1, 1'b1, 8'h01));
    send_item(mk_item(FUNC_POLL, 32'd80, 1'b0, 1'b1, 8'h02));
    send_item(mk_item(FUNC_POLL, 32'd85, 1'b0, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd90, 1'b0, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd100, 1'b0, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd200, 1'b1, 1'b1, 8'h03));
    send_item(mk_item(FUNC_POLL, 32'd4100, 1'b0, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd8100, 1'b1, 1'b1, 8'h04));
    send_item(mk_item(FUNC_POLL, 32'd8110, 1'b0, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd8120, 1'b0, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd8130, 1'b0, 1'b0, 8'h00));
    send_item(mk_item(FUNC_BOOT, 32'd8135, 1'b1, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd8140, 1'b1, 1'b1, 8'h2A));
    send_item(mk_item(FUNC_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00));
    send_item(mk_item(FUNC_POLL, 32'd5, 1'b1, 1'b1, 8'h55));
    send_item(mk_item(FUNC_POLL, 32'd9, 1'b1, 1'b1, 8'h56));
    end_burst();
  endtask

  task automatic test_fast_extremes();
    set_config(16'd0, 16'd0, 8'd1);
    run_traffic(30, 3, $urandom());
  endtask

  task automatic test_slow_extremes();
    set_config(16'hFFFF, 16'hFFFF, 8'd255);
    run_traffic(20, 140000, $urandom());
  endtask

  // Drives the failure count into saturation, then boots a lost device and fails it again.
  task automatic test_failure_saturation();
    set_config(16'd0, 16'hFFFF, 8'd255);
    send_item(mk_item(FUNC_BOOT, $urandom(), 1'b1, 1'b0, 8'd0));
    repeat (258) begin
      send_item(mk_item(FUNC_POLL, $urandom(), 1'b0, 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255))));
    end
    send_item(mk_item(FUNC_BOOT, $urandom(), 1'b1, 1'b0, 8'd0));
    repeat (3) begin
      send_item(mk_item(FUNC_POLL, $urandom(), 1'b0, 1'b1, 8'($urandom_range(0, 255))));
    end
    end_burst();
  endtask

  task automatic test_wrapping_time();
    set_config(16'd10, 16'd40, 8'd2);
    run_traffic(20, 20, 32'hFFFF_FF80);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      set_config(16'($urandom_range(0, 60)), 16'($urandom_range(0, 200)),
                 8'($urandom_range(1, 6)));
      run_traffic(12, 30, $urandom());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (key_report_q.size() == 0) begin
          $error("result beat with no expectation pending");
          mismatches++;
        end else begin
          out_item_t want;
          want = key_report_q.pop_front();
          results_checked++;
          if (out_ch.data.key_event !== want.key_event) begin
            $error("key_event: expected %0d, actual %0d", want.key_event,
                   out_ch.data.key_event);
            mismatches++;
          end
          if (out_ch.data.bus_action !== want.bus_action) begin
            $error("bus_action: expected %0d, actual %0d", want.bus_action,
                   out_ch.data.bus_action);
            mismatches++;
          end
          if (out_ch.data.device_present !== want.device_present) begin
            $error("device_present: expected %0d, actual %0d", want.device_present,
                   out_ch.data.device_present);
            mismatches++;
          end
          if (out_ch.data.device_lost !== want.device_lost) begin
            $error("device_lost: expected %0d, actual %0d", want.device_lost,
                   out_ch.data.device_lost);
            mismatches++;
          end
          if (out_ch.data.last_nonzero_key !== want.last_nonzero_key) begin
            $error("last_nonzero_key: expected %0d, actual %0d", want.last_nonzero_key,
                   out_ch.data.last_nonzero_key);
            mismatches++;
          end
        end
        if (sink_quiet > 0) begin
          sink_quiet--;
          sink_wait = 0;
        end else if ($urandom_range(0, 9) == 0) begin
          sink_quiet = $urandom_range(8, 30);
          sink_wait = 0;
        end else begin
          sink_wait = $urandom_range(0, 14);
        end
      end
      if (sink_wait > 0) begin
        sink_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("keypad_poll_presence_tracker_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    src_quiet = 0;
    cur_poll_intv = PollIntervalRst;
    cur_reprobe_intv = ReprobeIntervalRst;
    cur_fail_limit = FailureLimitRst;
    trk_present = 1'b0;
    trk_lost = 1'b0;
    trk_fails = '0;
    trk_poll_ms = '0;
    trk_reprobe_ms = '0;
    trk_prev_key = '0;
    trk_seen_byte = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults_directed();
    test_fast_extremes();
    test_slow_extremes();
    test_failure_saturation();
    test_wrapping_time();
    test_random_settings();
    settle();

    if (key_report_q.size() != 0) begin
      $error("%0d expected result beats never arrived", key_report_q.size());
      mismatches++;
    end
    $display("Sent %0d input beats and checked %0d result beats over eight register settings,",
             items_sent, results_checked);
    $display("including interval and failure-limit extremes, count saturation and time wrap.");
    if (mismatches == 0) begin
      $display("keypad_poll_presence_tracker_unit_tb: clean");
    end else begin
      $display("keypad_poll_presence_tracker_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/kppt_pkg.sv
hdl/kppt_channels.sv
hdl/keypad_poll_presence_tracker_unit.sv
dv/keypad_poll_presence_tracker_unit_tb.sv
